FILE: sv/twsp_pkg.sv
// ----------------------------------------------------------------------------
// twsp_pkg
// Shared types and constants of the trigger window segment planner.
// ----------------------------------------------------------------------------
package twsp_pkg;

    localparam int NUM_SOURCES      = 16;
    localparam int WORDS_PER_SAMPLE = 40;
    localparam int POLLS_DIVISOR    = 1000;
    localparam int QUEUE_DEPTH      = 2;
    localparam int WIDE_W           = 34;

    localparam logic [7:0] WAIT_MAX = 8'hFF;

    localparam logic [1:0] CLS_INJECTION = 2'd3;

    localparam logic [2:0] CFG_BUFFER_BASE     = 3'd0;
    localparam logic [2:0] CFG_BUFFER_LENGTH   = 3'd1;
    localparam logic [2:0] CFG_PRE_POINTS      = 3'd2;
    localparam logic [2:0] CFG_POST_POINTS     = 3'd3;
    localparam logic [2:0] CFG_INJ_PRE_POINTS  = 3'd4;
    localparam logic [2:0] CFG_INJ_POST_POINTS = 3'd5;

    localparam logic [31:0] RST_BUFFER_BASE     = 32'h1000_0000;
    localparam logic [28:0] RST_BUFFER_LENGTH   = 29'h01E8_4800;
    localparam logic [17:0] RST_PRE_POINTS      = 18'd50000;
    localparam logic [17:0] RST_POST_POINTS     = 18'd50000;
    localparam logic [17:0] RST_INJ_PRE_POINTS  = 18'd0;
    localparam logic [17:0] RST_INJ_POST_POINTS = 18'd8000;

    typedef struct packed {
        logic [31:0] buffer_base;
        logic [28:0] buffer_length;
        logic [17:0] pre_points;
        logic [17:0] post_points;
        logic [17:0] inj_pre_points;
        logic [17:0] inj_post_points;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  source;
        logic [31:0] pointer;
        logic [17:0] pre;
        logic [17:0] post;
        logic [31:0] count;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CMP,
        BK_SEG,
        BK_EMIT
    } t_back_state;

endpackage

FILE: sv/twsp_front.sv
// ----------------------------------------------------------------------------
// twsp_front
// Per-source trigger state: latch pointers, arm, count polls and issue a
// window job when the wait threshold is reached.
// ----------------------------------------------------------------------------
module twsp_front #(
    parameter int POLLS_DIVISOR = twsp_pkg::POLLS_DIVISOR
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  twsp_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [3:0]       i_source_index,
    input  logic [31:0]      i_buffer_pointer,
    input  logic             i_q_full,
    output logic             o_q_push,
    output twsp_pkg::t_job   o_q_job
);

    localparam int NSRC   = twsp_pkg::NUM_SOURCES;
    localparam int DIV_W  = $clog2(POLLS_DIVISOR + 1);
    localparam int PROD_W = 9 + DIV_W;
    localparam int CMP_W  = (PROD_W > 18) ? PROD_W : 18;

    logic [31:0] r_last [NSRC];
    logic        r_armed [NSRC];
    logic [7:0]  r_wait [NSRC];
    logic [31:0] r_sent [NSRC];

    logic              accept;
    logic              src_ok;
    logic              take;
    logic              armed_eff;
    logic [31:0]       ptr_eff;
    logic [7:0]        wait_eff;
    logic [8:0]        wait_inc;
    logic [PROD_W-1:0] prod;
    logic              wait_lt;
    logic [17:0]       pre_sel;
    logic [17:0]       post_sel;
    logic [31:0]       sent_inc;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign src_ok     = ({1'b0, i_source_index} < 5'(NSRC));

    always_comb begin
        take      = !r_armed[i_source_index] &&
                    (i_buffer_pointer != r_last[i_source_index]);
        armed_eff = r_armed[i_source_index] || take;
        ptr_eff   = take ? i_buffer_pointer : r_last[i_source_index];
        wait_eff  = take ? 8'd0 : r_wait[i_source_index];
        wait_inc  = {1'b0, wait_eff} + 9'd1;
        if (i_source_index[3:2] == twsp_pkg::CLS_INJECTION) begin
            pre_sel  = i_cfg.inj_pre_points;
            post_sel = i_cfg.inj_post_points;
        end else begin
            pre_sel  = i_cfg.pre_points;
            post_sel = i_cfg.post_points;
        end
        prod     = PROD_W'(wait_inc) * PROD_W'(POLLS_DIVISOR);
        wait_lt  = (wait_eff != twsp_pkg::WAIT_MAX) &&
                   (CMP_W'(prod) <= CMP_W'(post_sel));
        sent_inc = r_sent[i_source_index] + 32'd1;

        o_q_push        = accept && src_ok && armed_eff && !wait_lt;
        o_q_job.source  = i_source_index;
        o_q_job.pointer = ptr_eff;
        o_q_job.pre     = pre_sel;
        o_q_job.post    = post_sel;
        o_q_job.count   = sent_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSRC; i++) begin
                r_last[i]  <= '0;
                r_armed[i] <= 1'b0;
                r_wait[i]  <= '0;
                r_sent[i]  <= '0;
            end
        end else if (accept && src_ok && armed_eff) begin
            r_last[i_source_index] <= ptr_eff;
            if (wait_lt) begin
                r_armed[i_source_index] <= 1'b1;
                r_wait[i_source_index]  <= wait_inc[7:0];
            end else begin
                r_armed[i_source_index] <= 1'b0;
                r_wait[i_source_index]  <= wait_eff;
                r_sent[i_source_index]  <= sent_inc;
            end
        end
    end

endmodule

FILE: sv/twsp_queue.sv
// ----------------------------------------------------------------------------
// twsp_queue
// Short job queue between the trigger front end and the segment back end.
// ----------------------------------------------------------------------------
module twsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  twsp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output twsp_pkg::t_job o_job
);

    localparam int DEPTH = twsp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    twsp_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/twsp_back.sv
// ----------------------------------------------------------------------------
// twsp_back
// Window planner: size the pre/post window, find the wrap case and emit one
// or three segment descriptors through an output register.
// ----------------------------------------------------------------------------
module twsp_back #(
    parameter int WORDS_PER_SAMPLE = twsp_pkg::WORDS_PER_SAMPLE
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  twsp_pkg::t_cfg i_cfg,
    input  logic           i_q_empty,
    input  twsp_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [3:0]     o_out_source,
    output logic [1:0]     o_source_class,
    output logic [2:0]     o_channel_number,
    output logic [31:0]    o_segment_address,
    output logic [23:0]    o_segment_words,
    output logic [31:0]    o_send_count,
    output logic           o_last
);

    localparam int W     = twsp_pkg::WIDE_W;
    localparam int WPS_W = $clog2(WORDS_PER_SAMPLE + 1);
    localparam int MW    = 18 + WPS_W;

    twsp_pkg::t_back_state r_state;
    twsp_pkg::t_back_state n_state;

    twsp_pkg::t_job r_job;
    logic [W-1:0]   r_pre_w;
    logic [W-1:0]   r_post_w;
    logic [W-1:0]   r_end;
    logic           r_pre_wrap;
    logic           r_post_wrap;
    logic [W-1:0]   r_lo_diff;
    logic           r_lo_ok;
    logic [W-1:0]   r_hi_diff;
    logic           r_hi_ok;
    logic [W-1:0]   r_n1;
    logic [W-1:0]   r_n2;
    logic [1:0]     r_k;
    logic [1:0]     r_kmax;
    logic           r_out_valid;

    logic [MW-1:0]  pre_prod;
    logic [MW-1:0]  post_prod;
    logic [W-1:0]   base_w;
    logic [W-1:0]   ptr_w;
    logic [W-1:0]   end_w;
    logic [W-1:0]   seg_addr;
    logic [W-1:0]   seg_words;
    logic [W-1:0]   n1_next;
    logic [W-1:0]   n2_next;
    logic           out_free;
    logic           load_out;
    logic           seg_last;

    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign base_w      = W'(i_cfg.buffer_base);
    assign ptr_w       = W'(r_job.pointer);
    assign end_w       = base_w + W'(i_cfg.buffer_length);
    assign pre_prod    = MW'(r_job.pre) * MW'(WORDS_PER_SAMPLE);
    assign post_prod   = MW'(r_job.post) * MW'(WORDS_PER_SAMPLE);
    assign seg_last    = (r_k == r_kmax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twsp_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            twsp_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = twsp_pkg::BK_MUL;
                end
            end
            twsp_pkg::BK_MUL: begin
                n_state = twsp_pkg::BK_CMP;
            end
            twsp_pkg::BK_CMP: begin
                n_state = twsp_pkg::BK_SEG;
            end
            twsp_pkg::BK_SEG: begin
                n_state = twsp_pkg::BK_EMIT;
            end
            twsp_pkg::BK_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (seg_last) begin
                        n_state = twsp_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = twsp_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (r_pre_wrap) begin
            n2_next = r_lo_ok ? (r_lo_diff >> 2) : '0;
            n1_next = r_pre_w - n2_next;
        end else if (r_post_wrap) begin
            n1_next = r_hi_ok ? (r_hi_diff >> 2) : '0;
            n2_next = r_post_w - n1_next;
        end else begin
            n1_next = r_pre_w + r_post_w;
            n2_next = '0;
        end
    end

    always_comb begin
        seg_addr  = ptr_w - (r_pre_w << 2);
        seg_words = r_n1;
        priority if (r_pre_wrap) begin
            unique case (r_k)
                2'd0: begin
                    seg_addr  = r_end - (r_n1 << 2);
                    seg_words = r_n1;
                end
                2'd1: begin
                    seg_addr  = base_w;
                    seg_words = r_n2;
                end
                default: begin
                    seg_addr  = ptr_w;
                    seg_words = r_post_w;
                end
            endcase
        end else if (r_post_wrap) begin
            unique case (r_k)
                2'd0: begin
                    seg_addr  = ptr_w - (r_pre_w << 2);
                    seg_words = r_pre_w;
                end
                2'd1: begin
                    seg_addr  = ptr_w;
                    seg_words = r_n1;
                end
                default: begin
                    seg_addr  = base_w;
                    seg_words = r_n2;
                end
            endcase
        end else begin
            seg_addr  = ptr_w - (r_pre_w << 2);
            seg_words = r_n1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            twsp_pkg::BK_IDLE: begin
                r_job <= i_q_job;
                r_k   <= 2'd0;
            end
            twsp_pkg::BK_MUL: begin
                r_pre_w  <= W'(pre_prod);
                r_post_w <= W'(post_prod);
            end
            twsp_pkg::BK_CMP: begin
                r_end       <= end_w;
                r_pre_wrap  <= ptr_w < (base_w + (r_pre_w << 2));
                r_post_wrap <= (ptr_w + (r_post_w << 2)) > end_w;
                r_lo_diff   <= ptr_w - base_w;
                r_lo_ok     <= ptr_w >= base_w;
                r_hi_diff   <= end_w - ptr_w;
                r_hi_ok     <= end_w >= ptr_w;
            end
            twsp_pkg::BK_SEG: begin
                r_n1   <= n1_next;
                r_n2   <= n2_next;
                r_kmax <= (r_pre_wrap || r_post_wrap) ? 2'd2 : 2'd0;
            end
            twsp_pkg::BK_EMIT: begin
                if (load_out) begin
                    r_k <= r_k + 2'd1;
                end
            end
            default: begin
                r_k <= 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out_source      <= r_job.source;
            o_source_class    <= r_job.source[3:2];
            o_channel_number  <= {1'b0, r_job.source[1:0]} + 3'd1;
            o_segment_address <= seg_addr[31:0];
            o_segment_words   <= seg_words[23:0];
            o_send_count      <= r_job.count;
            o_last            <= seg_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: sv/trigger_window_segment_planner_top.sv
// ----------------------------------------------------------------------------
// trigger_window_segment_planner_top
// Polls trigger sources and plans the circular-buffer segments of each window.
// A firing poll is queued; the planner steps it through BK_MUL, BK_CMP, BK_SEG
// and loads its first segment in BK_EMIT. Throughput: one poll per cycle while
// the two-entry job queue has room; one window at a time, of 1 or 3 segments.
// Reset: synchronous; clears all per-source state, loads register defaults.
// ----------------------------------------------------------------------------
module trigger_window_segment_planner_top #(
    parameter int WORDS_PER_SAMPLE = twsp_pkg::WORDS_PER_SAMPLE,
    parameter int POLLS_DIVISOR    = twsp_pkg::POLLS_DIVISOR
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_source_index,
    input  logic [31:0] i_buffer_pointer,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_out_source,
    output logic [1:0]  o_source_class,
    output logic [2:0]  o_channel_number,
    output logic [31:0] o_segment_address,
    output logic [23:0] o_segment_words,
    output logic [31:0] o_send_count,
    output logic        o_last
);

    twsp_pkg::t_cfg r_cfg;
    twsp_pkg::t_job push_job;
    twsp_pkg::t_job head_job;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_base     <= twsp_pkg::RST_BUFFER_BASE;
            r_cfg.buffer_length   <= twsp_pkg::RST_BUFFER_LENGTH;
            r_cfg.pre_points      <= twsp_pkg::RST_PRE_POINTS;
            r_cfg.post_points     <= twsp_pkg::RST_POST_POINTS;
            r_cfg.inj_pre_points  <= twsp_pkg::RST_INJ_PRE_POINTS;
            r_cfg.inj_post_points <= twsp_pkg::RST_INJ_POST_POINTS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                twsp_pkg::CFG_BUFFER_BASE:     r_cfg.buffer_base     <= i_cfg_data;
                twsp_pkg::CFG_BUFFER_LENGTH:   r_cfg.buffer_length   <= i_cfg_data[28:0];
                twsp_pkg::CFG_PRE_POINTS:      r_cfg.pre_points      <= i_cfg_data[17:0];
                twsp_pkg::CFG_POST_POINTS:     r_cfg.post_points     <= i_cfg_data[17:0];
                twsp_pkg::CFG_INJ_PRE_POINTS:  r_cfg.inj_pre_points  <= i_cfg_data[17:0];
                twsp_pkg::CFG_INJ_POST_POINTS: r_cfg.inj_post_points <= i_cfg_data[17:0];
                default: begin
                end
            endcase
        end
    end

    twsp_front #(
        .POLLS_DIVISOR(POLLS_DIVISOR)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_source_index  (i_source_index),
        .i_buffer_pointer(i_buffer_pointer),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (push_job)
    );

    twsp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_job  (head_job)
    );

    twsp_back #(
        .WORDS_PER_SAMPLE(WORDS_PER_SAMPLE)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (q_empty),
        .i_q_job          (head_job),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_source     (o_out_source),
        .o_source_class   (o_source_class),
        .o_channel_number (o_channel_number),
        .o_segment_address(o_segment_address),
        .o_segment_words  (o_segment_words),
        .o_send_count     (o_send_count),
        .o_last           (o_last)
    );

endmodule

FILE: tb/trigger_window_segment_planner_top_test.sv
// ----------------------------------------------------------------------------
// trigger_window_segment_planner_top_test
// Self-checking bench: polls trigger sources through a queued driver, predicts
// each window's segment descriptors per source, and checks every output
// transaction in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module trigger_window_segment_planner_top_test;

    localparam int BYTES_PER_SAMPLE = twsp_pkg::WORDS_PER_SAMPLE * 4;
    localparam int SETTLE_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_POLLS      = 12;
    localparam int MAX_REPORTS      = 10;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [3:0]  source;
        logic [31:0] pointer;
    } t_poll;

    typedef struct packed {
        logic [3:0]  source;
        logic [1:0]  cls;
        logic [2:0]  channel;
        logic [31:0] addr;
        logic [23:0] words;
        logic [31:0] count;
        logic        is_last;
    } t_segment;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_source_index;
    logic [31:0] i_buffer_pointer;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_out_source;
    logic [1:0]  o_source_class;
    logic [2:0]  o_channel_number;
    logic [31:0] o_segment_address;
    logic [23:0] o_segment_words;
    logic [31:0] o_send_count;
    logic        o_last;

    twsp_pkg::t_cfg cfg_shadow;
    logic [31:0] src_pointer [twsp_pkg::NUM_SOURCES];
    logic        src_armed   [twsp_pkg::NUM_SOURCES];
    logic [7:0]  src_wait    [twsp_pkg::NUM_SOURCES];
    logic [31:0] src_sent    [twsp_pkg::NUM_SOURCES];
    logic [31:0] stim_last_ptr [twsp_pkg::NUM_SOURCES];

    t_poll       poll_queue[$];
    t_segment    expected_segments[$];
    t_poll       next_poll;
    t_segment    got_seg;
    t_segment    want_seg;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;

    trigger_window_segment_planner_top DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic void add_segment(input logic [3:0] src, input logic [63:0] addr,
                                        input logic [63:0] words, input logic [31:0] cnt,
                                        input logic is_last);
        t_segment s;
        s.source  = src;
        s.cls     = src[3:2];
        s.channel = {1'b0, src[1:0]} + 3'd1;
        s.addr    = addr[31:0];
        s.words   = words[23:0];
        s.count   = cnt;
        s.is_last = is_last;
        expected_segments.push_back(s);
    endfunction

    function automatic void plan_window(input logic [3:0] src, input logic [31:0] ptr);
        logic [63:0] pre, post, thr, base, fin, p, n1, n2;
        logic [31:0] cnt;
        if (int'(src) >= twsp_pkg::NUM_SOURCES) return;
        if (!src_armed[src] && ptr != src_pointer[src]) begin
            src_armed[src]   = 1'b1;
            src_pointer[src] = ptr;
            src_wait[src]    = '0;
        end
        if (!src_armed[src]) return;
        if (src[3:2] == twsp_pkg::CLS_INJECTION) begin
            pre  = 64'(cfg_shadow.inj_pre_points);
            post = 64'(cfg_shadow.inj_post_points);
        end else begin
            pre  = 64'(cfg_shadow.pre_points);
            post = 64'(cfg_shadow.post_points);
        end
        thr = post / twsp_pkg::POLLS_DIVISOR;
        if (thr > 64'(twsp_pkg::WAIT_MAX)) thr = 64'(twsp_pkg::WAIT_MAX);
        if (64'(src_wait[src]) < thr) begin
            src_wait[src] = src_wait[src] + 8'd1;
            return;
        end
        src_armed[src] = 1'b0;
        src_sent[src]  = src_sent[src] + 32'd1;
        cnt  = src_sent[src];
        base = 64'(cfg_shadow.buffer_base);
        fin  = base + 64'(cfg_shadow.buffer_length);
        p    = 64'(src_pointer[src]);
        if (p < base + pre * BYTES_PER_SAMPLE) begin
            n2 = (p >= base) ? (p - base) >> 2 : 64'd0;
            n1 = pre * twsp_pkg::WORDS_PER_SAMPLE - n2;
            add_segment(src, fin - n1 * 4, n1, cnt, 1'b0);
            add_segment(src, base, n2, cnt, 1'b0);
            add_segment(src, p, post * twsp_pkg::WORDS_PER_SAMPLE, cnt, 1'b1);
        end else if (p + post * BYTES_PER_SAMPLE > fin) begin
            n1 = (fin >= p) ? (fin - p) >> 2 : 64'd0;
            n2 = post * twsp_pkg::WORDS_PER_SAMPLE - n1;
            add_segment(src, p - pre * BYTES_PER_SAMPLE, pre * twsp_pkg::WORDS_PER_SAMPLE,
                        cnt, 1'b0);
            add_segment(src, p, n1, cnt, 1'b0);
            add_segment(src, base, n2, cnt, 1'b1);
        end else begin
            add_segment(src, p - pre * BYTES_PER_SAMPLE,
                        (pre + post) * twsp_pkg::WORDS_PER_SAMPLE, cnt, 1'b1);
        end
    endfunction

    function automatic logic [31:0] pick_pointer(input logic [3:0] src);
        logic [63:0] base, fin, pre, post, p;
        base = 64'(cfg_shadow.buffer_base);
        fin  = base + 64'(cfg_shadow.buffer_length);
        if (src[3:2] == twsp_pkg::CLS_INJECTION) begin
            pre  = 64'(cfg_shadow.inj_pre_points);
            post = 64'(cfg_shadow.inj_post_points);
        end else begin
            pre  = 64'(cfg_shadow.pre_points);
            post = 64'(cfg_shadow.post_points);
        end
        case ($urandom_range(0, 9))
            0:       p = 64'($urandom());
            1:       p = base - 64'($urandom_range(0, 64));
            2, 3:    p = base + 64'($urandom_range(0, cfg_shadow.buffer_length));
            4:       p = base + pre * BYTES_PER_SAMPLE + 64'($urandom_range(0, 8)) - 64'd4;
            5:       p = fin - post * BYTES_PER_SAMPLE + 64'($urandom_range(0, 8)) - 64'd4;
            6:       p = fin + 64'($urandom_range(0, 64));
            7:       p = 64'(stim_last_ptr[src]);
            8:       p = $urandom_range(0, 1) ? 64'h0 : 64'hFFFF_FFFF;
            default: p = base + 64'd4 * $urandom_range(0, cfg_shadow.buffer_length / 4);
        endcase
        return p[31:0];
    endfunction

    function automatic string describe(input t_segment s);
        return $sformatf("src %0d class %0d chan %0d addr %08h words %0d count %0d last %0b",
                         s.source, s.cls, s.channel, s.addr, s.words, s.count, s.is_last);
    endfunction

    task automatic queue_poll(input logic [3:0] src, input logic [31:0] ptr);
        t_poll item;
        item.source  = src;
        item.pointer = ptr;
        stim_last_ptr[src] = ptr;
        poll_queue.push_back(item);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            twsp_pkg::CFG_BUFFER_BASE:     cfg_shadow.buffer_base     = data;
            twsp_pkg::CFG_BUFFER_LENGTH:   cfg_shadow.buffer_length   = data[28:0];
            twsp_pkg::CFG_PRE_POINTS:      cfg_shadow.pre_points      = data[17:0];
            twsp_pkg::CFG_POST_POINTS:     cfg_shadow.post_points     = data[17:0];
            twsp_pkg::CFG_INJ_PRE_POINTS:  cfg_shadow.inj_pre_points  = data[17:0];
            twsp_pkg::CFG_INJ_POST_POINTS: cfg_shadow.inj_post_points = data[17:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] base, input logic [31:0] len,
                                 input logic [31:0] pre, input logic [31:0] post,
                                 input logic [31:0] inj_pre, input logic [31:0] inj_post);
        write_register(twsp_pkg::CFG_BUFFER_BASE, base);
        write_register(twsp_pkg::CFG_BUFFER_LENGTH, len);
        write_register(twsp_pkg::CFG_PRE_POINTS, pre);
        write_register(twsp_pkg::CFG_POST_POINTS, post);
        write_register(twsp_pkg::CFG_INJ_PRE_POINTS, inj_pre);
        write_register(twsp_pkg::CFG_INJ_POST_POINTS, inj_post);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (poll_queue.size() != 0 || i_in_valid || expected_segments.size() != 0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                plan_window(i_source_index, i_buffer_pointer);
            end
            if (!i_in_valid || o_in_ready) begin
                if (poll_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_poll = poll_queue.pop_front();
                    i_in_valid       <= 1'b1;
                    i_source_index   <= next_poll.source;
                    i_buffer_pointer <= next_poll.pointer;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_seg.source  = o_out_source;
                got_seg.cls     = o_source_class;
                got_seg.channel = o_channel_number;
                got_seg.addr    = o_segment_address;
                got_seg.words   = o_segment_words;
                got_seg.count   = o_send_count;
                got_seg.is_last = o_last;
                if (expected_segments.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("unexpected transaction: %s", describe(got_seg));
                    end
                    mismatches++;
                end else begin
                    want_seg = expected_segments.pop_front();
                    if (got_seg !== want_seg) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("segment mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want_seg));
                            $display("  actual   %s", describe(got_seg));
                        end
                        mismatches++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [3:0]  hot_a, hot_b, src;
        logic [31:0] b, e;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_source_index   = '0;
        i_buffer_pointer = '0;
        i_out_ready      = 1'b0;
        cfg_shadow = '{twsp_pkg::RST_BUFFER_BASE, twsp_pkg::RST_BUFFER_LENGTH,
                       twsp_pkg::RST_PRE_POINTS, twsp_pkg::RST_POST_POINTS,
                       twsp_pkg::RST_INJ_PRE_POINTS, twsp_pkg::RST_INJ_POST_POINTS};
        for (int s = 0; s < twsp_pkg::NUM_SOURCES; s++) begin
            src_pointer[s]   = '0;
            src_armed[s]     = 1'b0;
            src_wait[s]      = '0;
            src_sent[s]      = '0;
            stim_last_ptr[s] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: injection source waits out its polls, user source stays armed
        queue_poll(4'd12, twsp_pkg::RST_BUFFER_BASE + 32'h100);
        for (int k = 0; k < 8; k++) queue_poll(4'd12, $urandom());
        queue_poll(4'd0, twsp_pkg::RST_BUFFER_BASE);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        b = 32'h1000_0000;
        e = b + 32'd1600;
        load_settings(b, 32'd1600, 32'd2, 32'd3, 32'd0, 32'd999);
        write_register(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_register(CFG_SPARE_HI, 32'h0000_0000);
        queue_poll(4'd0, b + 32'd800);
        queue_poll(4'd1, b + 32'd800);
        queue_poll(4'd2, b + 32'd100);
        queue_poll(4'd3, b - 32'd4);
        queue_poll(4'd4, b + 32'd1400);
        queue_poll(4'd5, e + 32'd40);
        queue_poll(4'd6, 32'h0);
        queue_poll(4'd7, 32'hFFFF_FFFF);
        queue_poll(4'd8, b + 32'd320);
        queue_poll(4'd9, b + 32'd1120);
        queue_poll(4'd10, b + 32'd1124);
        queue_poll(4'd12, b);
        queue_poll(4'd15, b + 32'd3);
        queue_poll(4'd1, b + 32'd800);
        queue_poll(4'd1, b + 32'd804);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (ph == 0) begin
                load_settings(32'h0, 32'd160, 32'd0, 32'd0, 32'd0, 32'd0);
            end else if (ph == 1) begin
                load_settings(32'hFFFF_FFFF, 32'h1000_0000, 32'd200000, 32'd2999,
                              32'd200000, 32'd999);
            end else begin
                load_settings($urandom(),
                              ($urandom_range(0, 3) != 0) ? $urandom_range(160, 4000)
                                                          : $urandom_range(160, 32'h1000_0000),
                              ($urandom_range(0, 3) != 0) ? $urandom_range(0, 10)
                                                          : $urandom_range(0, 200000),
                              $urandom_range(0, 2999),
                              ($urandom_range(0, 3) != 0) ? $urandom_range(0, 10)
                                                          : $urandom_range(0, 200000),
                              $urandom_range(0, 2999));
            end
            hot_a = 4'($urandom_range(0, 15));
            hot_b = 4'($urandom_range(0, 15));
            for (int k = 0; k < PHASE_POLLS; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: src = hot_a;
                    4, 5, 6:    src = hot_b;
                    default:    src = 4'($urandom_range(0, 15));
                endcase
                queue_poll(src, pick_pointer(src));
                // hold the sender until every result is back
                if (ph == 3 && k == PHASE_POLLS / 2) drain();
            end
            drain();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        // long pre window with a short wait
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        load_settings(32'hF000_0000, 32'h1000_0000, 32'd200000, 32'd9999,
                      32'h3FFFF, 32'd9999);
        queue_poll(4'd13, 32'hF800_0000);
        for (int k = 0; k < 9; k++) queue_poll(4'd13, $urandom());
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_segments.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
